FILE: sv/rv32d_pkg.sv
`timescale 1ns / 1ps
// Package for the RV32I instruction decoder: opcode and funct constants,
// mnemonic and format codes, the decode result type and funct3 lookup tables.
// Depends on nothing.
package rv32d_pkg;

    // Major opcodes, instruction bits 6..0.
    localparam logic [6:0] OPC_R      = 7'b0110011;
    localparam logic [6:0] OPC_IARITH = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;

    // funct7 values that select between instruction variants.
    localparam logic [6:0] F7_ZERO = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // funct3 values that need special handling.
    localparam logic [2:0] F3_ADD_SUB = 3'b000;
    localparam logic [2:0] F3_SLL     = 3'b001;
    localparam logic [2:0] F3_SRL_SRA = 3'b101;

    // Mnemonic codes; zero means the word has no known mnemonic.
    typedef enum logic [5:0] {
        MN_UNKNOWN = 6'd0,
        MN_ADD   = 6'd1,  MN_SUB   = 6'd2,  MN_XOR   = 6'd3,  MN_OR    = 6'd4,
        MN_AND   = 6'd5,  MN_SLL   = 6'd6,  MN_SLT   = 6'd7,  MN_SLTU  = 6'd8,
        MN_SRL   = 6'd9,  MN_SRA   = 6'd10, MN_SLTI  = 6'd11, MN_SLTIU = 6'd12,
        MN_ADDI  = 6'd13, MN_ANDI  = 6'd14, MN_XORI  = 6'd15, MN_ORI   = 6'd16,
        MN_SLLI  = 6'd17, MN_SRLI  = 6'd18, MN_SRAI  = 6'd19, MN_LB    = 6'd20,
        MN_LH    = 6'd21, MN_LW    = 6'd22, MN_LBU   = 6'd23, MN_LHU   = 6'd24,
        MN_SB    = 6'd25, MN_SH    = 6'd26, MN_SW    = 6'd27, MN_BEQ   = 6'd28,
        MN_BNE   = 6'd29, MN_BLT   = 6'd30, MN_BGE   = 6'd31, MN_BLTU  = 6'd32,
        MN_BGEU  = 6'd33, MN_LUI   = 6'd34, MN_AUIPC = 6'd35, MN_JAL   = 6'd36,
        MN_JALR  = 6'd37
    } mnemonic_t;

    // Operand format classes.
    typedef enum logic [2:0] {
        FMT_R      = 3'd0,
        FMT_IARITH = 3'd1,
        FMT_LOAD   = 3'd2,
        FMT_STORE  = 3'd3,
        FMT_BRANCH = 3'd4,
        FMT_U      = 3'd5,
        FMT_J      = 3'd6
    } format_t;

    // Decoded fields that depend on the opcode.
    typedef struct packed {
        mnemonic_t          mnemonic;
        format_t            fmt;
        logic signed [31:0] imm;
    } decode_t;

    // Register-register mnemonic by funct3 (funct7 variants handled by caller).
    function automatic mnemonic_t r_mnem(input logic [2:0] f3);
        mnemonic_t mn;
        unique case (f3)
            3'd0: mn = MN_ADD;
            3'd1: mn = MN_SLL;
            3'd2: mn = MN_SLT;
            3'd3: mn = MN_SLTU;
            3'd4: mn = MN_XOR;
            3'd5: mn = MN_SRL;
            3'd6: mn = MN_OR;
            default: mn = MN_AND;
        endcase
        return mn;
    endfunction

    // Register-immediate mnemonic by funct3.
    function automatic mnemonic_t i_mnem(input logic [2:0] f3);
        mnemonic_t mn;
        unique case (f3)
            3'd0: mn = MN_ADDI;
            3'd1: mn = MN_SLLI;
            3'd2: mn = MN_SLTI;
            3'd3: mn = MN_SLTIU;
            3'd4: mn = MN_XORI;
            3'd5: mn = MN_SRLI;
            3'd6: mn = MN_ORI;
            default: mn = MN_ANDI;
        endcase
        return mn;
    endfunction

    // Load mnemonic by funct3.
    function automatic mnemonic_t ld_mnem(input logic [2:0] f3);
        mnemonic_t mn;
        unique case (f3)
            3'd0: mn = MN_LB;
            3'd1: mn = MN_LH;
            3'd2: mn = MN_LW;
            3'd4: mn = MN_LBU;
            3'd5: mn = MN_LHU;
            default: mn = MN_UNKNOWN;
        endcase
        return mn;
    endfunction

    // Store mnemonic by funct3.
    function automatic mnemonic_t st_mnem(input logic [2:0] f3);
        mnemonic_t mn;
        unique case (f3)
            3'd0: mn = MN_SB;
            3'd1: mn = MN_SH;
            3'd2: mn = MN_SW;
            default: mn = MN_UNKNOWN;
        endcase
        return mn;
    endfunction

    // Branch mnemonic by funct3.
    function automatic mnemonic_t br_mnem(input logic [2:0] f3);
        mnemonic_t mn;
        unique case (f3)
            3'd0: mn = MN_BEQ;
            3'd1: mn = MN_BNE;
            3'd4: mn = MN_BLT;
            3'd5: mn = MN_BGE;
            3'd6: mn = MN_BLTU;
            3'd7: mn = MN_BGEU;
            default: mn = MN_UNKNOWN;
        endcase
        return mn;
    endfunction

endpackage

FILE: sv/rv32i_instruction_decoder_unit.sv
`timescale 1ns / 1ps
// RV32I instruction decoder: an input register, one level of decode logic and
// a result register. An accepted word reaches out_valid through both registers.
// Throughput is one item per cycle; each register stage advances whenever it
// is empty or its downstream side is not stalling.
// Reset (rst_n low, asynchronous) empties both stages; payload is not reset.
// Depends on rv32d_pkg and rv32d_decode.
module rv32i_instruction_decoder_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instruction_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         mnemonic,
    output logic [2:0]         operand_format,
    output logic [4:0]         dest_reg,
    output logic [4:0]         src1_reg,
    output logic [4:0]         src2_reg,
    output logic signed [31:0] immediate
);

    logic               word_valid_reg;
    logic [31:0]        word_reg;
    logic               out_valid_reg;
    rv32d_pkg::decode_t dec_next;
    rv32d_pkg::decode_t dec_reg;
    logic [14:0]        regs_reg;
    logic               out_adv;
    logic               in_adv;

    // Each stage moves when it is empty or the next stage takes its item.
    assign out_adv  = !out_valid_reg || !out_stall;
    assign in_adv   = !word_valid_reg || out_adv;
    assign in_stall = !in_adv;

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else if (in_adv)
        begin
            word_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid)
        begin
            word_reg <= instruction_word;
        end
    end

    rv32d_decode u_decode
    (
        .word (word_reg),
        .dec  (dec_next)
    );

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= word_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && word_valid_reg)
        begin
            dec_reg  <= dec_next;
            regs_reg <= {word_reg[11:7], word_reg[19:15], word_reg[24:20]};
        end
    end

    // Output ports.
    assign out_valid      = out_valid_reg;
    assign mnemonic       = dec_reg.mnemonic;
    assign operand_format = dec_reg.fmt;
    assign immediate      = dec_reg.imm;
    assign dest_reg       = regs_reg[14:10];
    assign src1_reg       = regs_reg[9:5];
    assign src2_reg       = regs_reg[4:0];

endmodule

FILE: sv/rv32d_decode.sv
`timescale 1ns / 1ps
// Combinational decode of one RV32I instruction word into mnemonic,
// format and immediate. Depends on rv32d_pkg.
module rv32d_decode
(
    input  logic [31:0]       word,
    output rv32d_pkg::decode_t dec
);

    logic [6:0]         opc;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic signed [31:0] imm_i;

    assign opc   = word[6:0];
    assign f3    = word[14:12];
    assign f7    = word[31:25];
    assign imm_i = {{20{word[31]}}, word[31:20]};

    // Opcode selects the format and immediate layout; funct fields pick the mnemonic.
    always_comb
    begin
        dec.mnemonic = rv32d_pkg::MN_UNKNOWN;
        dec.fmt      = rv32d_pkg::FMT_R;
        dec.imm      = '0;
        unique case (opc)
            rv32d_pkg::OPC_R:
            begin
                dec.fmt      = rv32d_pkg::FMT_R;
                dec.mnemonic = rv32d_pkg::r_mnem(f3);
                if (f3 == rv32d_pkg::F3_ADD_SUB || f3 == rv32d_pkg::F3_SRL_SRA)
                begin
                    if (f7 == rv32d_pkg::F7_ALT)
                    begin
                        dec.mnemonic = (f3 == rv32d_pkg::F3_ADD_SUB) ?
                                       rv32d_pkg::MN_SUB : rv32d_pkg::MN_SRA;
                    end
                    else if (f7 != rv32d_pkg::F7_ZERO)
                    begin
                        dec.mnemonic = rv32d_pkg::MN_UNKNOWN;
                    end
                end
            end
            rv32d_pkg::OPC_IARITH:
            begin
                dec.fmt      = rv32d_pkg::FMT_IARITH;
                dec.mnemonic = rv32d_pkg::i_mnem(f3);
                if (f3 == rv32d_pkg::F3_SLL || f3 == rv32d_pkg::F3_SRL_SRA)
                begin
                    // Shift amounts are unsigned.
                    dec.imm = {27'd0, word[24:20]};
                    if (f3 == rv32d_pkg::F3_SRL_SRA)
                    begin
                        if (f7 == rv32d_pkg::F7_ALT)
                        begin
                            dec.mnemonic = rv32d_pkg::MN_SRAI;
                        end
                        else if (f7 != rv32d_pkg::F7_ZERO)
                        begin
                            dec.mnemonic = rv32d_pkg::MN_UNKNOWN;
                        end
                    end
                end
                else
                begin
                    dec.imm = imm_i;
                end
            end
            rv32d_pkg::OPC_LOAD:
            begin
                dec.fmt      = rv32d_pkg::FMT_LOAD;
                dec.mnemonic = rv32d_pkg::ld_mnem(f3);
                dec.imm      = imm_i;
            end
            rv32d_pkg::OPC_STORE:
            begin
                dec.fmt      = rv32d_pkg::FMT_STORE;
                dec.mnemonic = rv32d_pkg::st_mnem(f3);
                dec.imm      = {{20{word[31]}}, word[31:25], word[11:7]};
            end
            rv32d_pkg::OPC_BRANCH:
            begin
                dec.fmt      = rv32d_pkg::FMT_BRANCH;
                dec.mnemonic = rv32d_pkg::br_mnem(f3);
                dec.imm      = {{19{word[31]}}, word[31], word[7], word[30:25],
                                word[11:8], 1'b0};
            end
            rv32d_pkg::OPC_LUI:
            begin
                dec.fmt      = rv32d_pkg::FMT_U;
                dec.mnemonic = rv32d_pkg::MN_LUI;
                dec.imm      = {word[31:12], 12'd0};
            end
            rv32d_pkg::OPC_AUIPC:
            begin
                dec.fmt      = rv32d_pkg::FMT_U;
                dec.mnemonic = rv32d_pkg::MN_AUIPC;
                dec.imm      = {word[31:12], 12'd0};
            end
            rv32d_pkg::OPC_JAL:
            begin
                dec.fmt      = rv32d_pkg::FMT_J;
                dec.mnemonic = rv32d_pkg::MN_JAL;
                dec.imm      = {{11{word[31]}}, word[31], word[19:12], word[20],
                                word[30:21], 1'b0};
            end
            rv32d_pkg::OPC_JALR:
            begin
                dec.fmt      = rv32d_pkg::FMT_LOAD;
                dec.mnemonic = rv32d_pkg::MN_JALR;
                dec.imm      = imm_i;
            end
            default:
            begin
                // Unknown opcode: all-zero result.
                dec.mnemonic = rv32d_pkg::MN_UNKNOWN;
                dec.fmt      = rv32d_pkg::FMT_R;
                dec.imm      = '0;
            end
        endcase
    end

endmodule
